// ===== hw/rtl/tod_pkg.sv =====
package tod_pkg;

    localparam int HOURS_W   = 5;
    localparam int MINUTES_W = 6;
    localparam int SECONDS_W = 6;
    localparam int CMD_W     = 3;
    localparam int ORDER_W   = 2;

    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 1;

    localparam logic [HOURS_W-1:0]   HOURS_PER_DAY   = 5'd24;
    localparam logic [MINUTES_W-1:0] MINUTES_PER_HR  = 6'd60;
    localparam logic [SECONDS_W-1:0] SECONDS_PER_MIN = 6'd60;

    localparam logic [ORDER_W-1:0] ORDER_EQUAL   = 2'b00;
    localparam logic [ORDER_W-1:0] ORDER_LATER   = 2'b01;
    localparam logic [ORDER_W-1:0] ORDER_EARLIER = 2'b11;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 3'd0,
        CMD_LOAD    = 3'd1,
        CMD_ADD     = 3'd2,
        CMD_DIFF    = 3'd3,
        CMD_COMPARE = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [HOURS_W-1:0]   hours;
        logic [MINUTES_W-1:0] minutes;
        logic [SECONDS_W-1:0] seconds;
    } t_time;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        t_time            operand;
    } t_item;

    typedef struct packed {
        t_time               res;
        logic [ORDER_W-1:0]  order;
        logic                day_carry;
        logic                error;
    } t_result;

    typedef struct packed {
        logic  update;
        t_time next_time;
    } t_state_upd;

endpackage

// ===== hw/rtl/tod_alu.sv =====
module tod_alu (
    input  tod_pkg::t_time      i_cur,
    input  tod_pkg::t_item      i_item,
    output tod_pkg::t_result    o_result,
    output tod_pkg::t_state_upd o_state
);
    import tod_pkg::*;

    t_time                opd;
    t_time                add_b;
    logic                 opd_ok;
    logic [SECONDS_W:0]   s_sum;
    logic [MINUTES_W:0]   m_sum;
    logic [HOURS_W:0]     h_sum;
    logic                 s_c;
    logic                 m_c;
    logic                 h_c;
    t_time                sum_time;
    logic                 cur_gt;
    logic                 cur_lt;
    t_time                big;
    t_time                sml;
    logic [SECONDS_W:0]   s_d;
    logic [MINUTES_W:0]   m_d;
    logic                 s_b;
    logic                 m_b;
    t_time                diff_time;

    assign opd    = i_item.operand;
    assign opd_ok = (opd.hours < HOURS_PER_DAY) && (opd.minutes < MINUTES_PER_HR)
                    && (opd.seconds < SECONDS_PER_MIN);

    always_comb begin
        if (i_item.command == CMD_TICK) begin
            add_b = '{hours: '0, minutes: '0, seconds: SECONDS_W'(1)};
        end else begin
            add_b = opd;
        end
        s_sum = {1'b0, i_cur.seconds} + {1'b0, add_b.seconds};
        s_c   = s_sum >= {1'b0, SECONDS_PER_MIN};
        sum_time.seconds = s_c ? SECONDS_W'(s_sum - {1'b0, SECONDS_PER_MIN})
                               : s_sum[SECONDS_W-1:0];
        m_sum = {1'b0, i_cur.minutes} + {1'b0, add_b.minutes} + {{MINUTES_W{1'b0}}, s_c};
        m_c   = m_sum >= {1'b0, MINUTES_PER_HR};
        sum_time.minutes = m_c ? MINUTES_W'(m_sum - {1'b0, MINUTES_PER_HR})
                               : m_sum[MINUTES_W-1:0];
        h_sum = {1'b0, i_cur.hours} + {1'b0, add_b.hours} + {{HOURS_W{1'b0}}, m_c};
        h_c   = h_sum >= {1'b0, HOURS_PER_DAY};
        sum_time.hours = h_c ? HOURS_W'(h_sum - {1'b0, HOURS_PER_DAY})
                             : h_sum[HOURS_W-1:0];
    end

    always_comb begin
        cur_gt = i_cur > opd;
        cur_lt = i_cur < opd;
        big    = cur_gt ? i_cur : opd;
        sml    = cur_gt ? opd : i_cur;
        s_d    = {1'b0, big.seconds} - {1'b0, sml.seconds};
        s_b    = s_d[SECONDS_W];
        diff_time.seconds = s_b ? SECONDS_W'(s_d + {1'b0, SECONDS_PER_MIN})
                                : s_d[SECONDS_W-1:0];
        m_d    = {1'b0, big.minutes} - {1'b0, sml.minutes} - {{MINUTES_W{1'b0}}, s_b};
        m_b    = m_d[MINUTES_W];
        diff_time.minutes = m_b ? MINUTES_W'(m_d + {1'b0, MINUTES_PER_HR})
                                : m_d[MINUTES_W-1:0];
        diff_time.hours = big.hours - sml.hours - {{(HOURS_W-1){1'b0}}, m_b};
    end

    always_comb begin
        o_result        = '0;
        o_state.update  = 1'b0;
        o_state.next_time = sum_time;
        unique case (i_item.command)
            CMD_TICK: begin
                o_result.res       = sum_time;
                o_result.day_carry = h_c;
                o_state.update     = 1'b1;
            end
            CMD_LOAD: begin
                if (opd_ok) begin
                    o_result.res      = opd;
                    o_state.update    = 1'b1;
                    o_state.next_time = opd;
                end else begin
                    o_result.error = 1'b1;
                end
            end
            CMD_ADD: begin
                if (opd_ok) begin
                    o_result.res       = sum_time;
                    o_result.day_carry = h_c;
                end else begin
                    o_result.error = 1'b1;
                end
            end
            CMD_DIFF: begin
                if (opd_ok) begin
                    o_result.res = diff_time;
                end else begin
                    o_result.error = 1'b1;
                end
            end
            CMD_COMPARE: begin
                if (opd_ok) begin
                    o_result.order = cur_gt ? ORDER_LATER :
                                     cur_lt ? ORDER_EARLIER : ORDER_EQUAL;
                end else begin
                    o_result.error = 1'b1;
                end
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/time_of_day_clock_arith.sv =====
// Time-of-day clock with time arithmetic. Each input word carries a command in
// s_tuser (tick, load, add, difference, compare) and an operand time in s_tdata;
// each produces exactly one output word. The clock state starts at 00:00:00.
// A word is registered on entry, then evaluated by the carry/borrow logic, which
// also updates the clock state, as it moves into the output register; one word is
// taken every cycle while the output is not stalled. The input ready follows the
// output ready while both stages hold a word.
module time_of_day_clock_arith (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // operand_hours[4:0], operand_minutes[10:5], operand_seconds[16:11], zero pad
    input  logic [tod_pkg::IN_TDATA_W-1:0]    s_tdata,
    // command[2:0]
    input  logic [tod_pkg::IN_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // res_hours[4:0], res_minutes[10:5], res_seconds[16:11], order[18:17],
    // day_carry[19], zero pad
    output logic [tod_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // error[0]
    output logic [tod_pkg::OUT_TUSER_W-1:0]   m_tuser
);
    import tod_pkg::*;

    t_time      r_cur;
    t_item      r_in;
    logic       r_in_valid;
    t_result    r_out;
    logic       r_out_valid;
    t_item      n_in;
    t_result    n_out;
    t_state_upd upd;
    logic       advance;

    assign advance  = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || advance;

    always_comb begin
        n_in.command         = s_tuser[CMD_W-1:0];
        n_in.operand.hours   = s_tdata[4:0];
        n_in.operand.minutes = s_tdata[10:5];
        n_in.operand.seconds = s_tdata[16:11];
    end

    tod_alu u_alu (
        .i_cur    (r_cur),
        .i_item   (r_in),
        .o_result (n_out),
        .o_state  (upd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cur       <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                if (upd.update) begin
                    r_cur <= upd.next_time;
                end
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in <= n_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {4'b0000, r_out.day_carry, r_out.order, r_out.res.seconds,
                       r_out.res.minutes, r_out.res.hours};
    assign m_tuser  = r_out.error;

endmodule
